// ===== rtl/sird_pkg.sv =====
// Shared constants, types and symbol lookup for the radix digit renderer.
package sird_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_RADIX   = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  // Field and register widths
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int SYM_W      = 8;
  localparam int NUM_SYMS   = 16;
  localparam int ALPHA_W    = NUM_SYMS * SYM_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMS_HIGH = 2'd2;

  // Reserved characters
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;

  // Divider status toward the sequencer
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  // Symbol byte for one digit out of the packed alphabet
  function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] alpha,
                                              input logic [DIGIT_W-1:0] d);
    return alpha[d*SYM_W +: SYM_W];
  endfunction

endpackage

// ===== rtl/signed_integer_to_radix_digits.sv =====
// Top level: renders signed integers as character strings in a configured radix.
// Each number taken on the input stream leaves as a run of character beats on the
// output stream, '-' first for a negative value, then digits most significant first,
// tlast on the final character. A number is taken only while the block is idle.
// The alphabet (radix plus up to 16 symbol bytes) is checked for each number; a bad
// alphabet drops the number with no output. Digits come from a bit-serial divider
// and are stacked in a small memory and read back in reverse.
module signed_integer_to_radix_digits #(
  parameter int MAX_RADIX   = sird_pkg::DEF_MAX_RADIX,
  parameter int VALUE_WIDTH = sird_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,   // [VALUE_WIDTH-1:0] value
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sird_pkg::SYM_W-1:0]          m_axis_tdata,   // [7:0] symbol
  output logic                                m_axis_tlast,   // is_last
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sird_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int AW      = $clog2(VALUE_WIDTH);
  localparam int DW      = sird_pkg::DIGIT_W;
  localparam int RW      = sird_pkg::RADIX_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;

  // Configuration registers
  logic [RW-1:0]                     radix;
  logic [sird_pkg::ALPHA_W-1:0]      alpha;

  // Sequencer state
  logic [2:0]                        state;
  logic [DW-1:0]                     chk_idx;
  logic                              bad;
  logic                              neg;
  logic [VALUE_WIDTH-1:0]            mag;
  logic [CNT_W-1:0]                  cnt;
  logic [CNT_W-1:0]                  ptr;
  logic                              div_start;

  // Digit stack
  logic [DW-1:0]                     stack [VALUE_WIDTH];
  logic [DW-1:0]                     rd_data;

  logic [VALUE_WIDTH-1:0]            quotient;
  sird_pkg::div_res_t                div_res;

  logic [VALUE_WIDTH-1:0]            raw;
  logic [VALUE_WIDTH-1:0]            mag_in;
  logic [sird_pkg::SYM_W-1:0]        cur_sym;
  logic                              chk_bad;
  logic                              out_free;
  logic                              emit;
  logic [CNT_W-1:0]                  ptr_m1;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign ptr_m1        = ptr - 1'b1;

  // A character is loaded into the output register this cycle
  assign emit = out_free && ((state == ST_SIGN && neg) || state == ST_LOAD);

  // Magnitude of the incoming value (most negative value wraps to its unsigned form)
  assign raw    = s_axis_tdata[VALUE_WIDTH-1:0];
  assign mag_in = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

  // One alphabet entry per cycle: radix range, reserved bytes, and duplicates among later entries
  always_comb begin
    cur_sym = sird_pkg::sym_at(alpha, chk_idx);
    chk_bad = (radix < RW'(2)) || (radix > RW'(MAX_RADIX));
    if ({1'b0, chk_idx} < radix) begin
      if (cur_sym == sird_pkg::CH_NUL || cur_sym == sird_pkg::CH_MINUS ||
          cur_sym == sird_pkg::CH_PLUS) begin
        chk_bad = 1'b1;
      end
      for (int j = 0; j < sird_pkg::NUM_SYMS; j++) begin
        if (DW'(j) > chk_idx && RW'(j) < radix &&
            sird_pkg::sym_at(alpha, DW'(j)) == cur_sym) begin
          chk_bad = 1'b1;
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= '0;
      alpha <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sird_pkg::CFG_RADIX:     radix <= cfg_data[RW-1:0];
        sird_pkg::CFG_SYMS_LOW:  alpha[sird_pkg::CFG_DATA_W-1:0] <= cfg_data;
        sird_pkg::CFG_SYMS_HIGH: alpha[sird_pkg::ALPHA_W-1:sird_pkg::CFG_DATA_W] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Digit divider
  sird_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (radix),
    .quotient (quotient),
    .res      (div_res)
  );

  // Digit stack: push from the divider, registered read at the emit pointer
  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_res.done) begin
      stack[cnt[AW-1:0]] <= div_res.rem;
    end
    rd_data <= stack[ptr_m1[AW-1:0]];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      chk_idx       <= '0;
      bad           <= 1'b0;
      neg           <= 1'b0;
      mag           <= '0;
      cnt           <= '0;
      ptr           <= '0;
      div_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // start the first division after a good check, the next one after each digit
      div_start <= (state == ST_CHECK && chk_idx == DW'(MAX_RADIX - 1) && !(bad || chk_bad)) ||
                   (state == ST_DIV && div_res.done && quotient != '0 &&
                    cnt != CNT_W'(VALUE_WIDTH - 1));
      m_axis_tvalid <= emit || (m_axis_tvalid && !m_axis_tready);
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            neg     <= raw[VALUE_WIDTH-1];
            mag     <= mag_in;
            chk_idx <= '0;
            bad     <= 1'b0;
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          chk_idx <= chk_idx + 1'b1;
          if (chk_idx == DW'(MAX_RADIX - 1)) begin
            if (bad || chk_bad) begin
              state <= ST_IDLE;
            end else begin
              cnt   <= '0;
              state <= ST_DIV;
            end
          end else begin
            bad <= bad || chk_bad;
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            cnt <= cnt + 1'b1;
            mag <= quotient;
            if (quotient == '0 || cnt == CNT_W'(VALUE_WIDTH - 1)) begin
              ptr   <= cnt + 1'b1;
              state <= ST_SIGN;
            end
          end
        end
        ST_SIGN: begin
          if (!neg) begin
            state <= ST_READ;
          end else if (out_free) begin
            m_axis_tdata  <= sird_pkg::CH_MINUS;
            m_axis_tlast  <= 1'b0;
            state         <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            m_axis_tdata  <= sird_pkg::sym_at(alpha, rd_data);
            m_axis_tlast  <= (ptr == CNT_W'(1));
            ptr           <= ptr_m1;
            state         <= (ptr == CNT_W'(1)) ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sird_div.sv =====
// Bit-serial restoring divider by a small radix: one quotient bit per cycle.
module sird_div #(
  parameter int VALUE_WIDTH = sird_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [VALUE_WIDTH-1:0]        dividend,
  input  logic [sird_pkg::RADIX_W-1:0]  divisor,
  output logic [VALUE_WIDTH-1:0]        quotient,
  output sird_pkg::div_res_t            res
);

  localparam int STEP_W = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0]        q;
  logic [sird_pkg::DIGIT_W-1:0]  rem;
  logic [STEP_W-1:0]             step;
  logic                          busy;
  logic                          done;
  logic [sird_pkg::RADIX_W-1:0]  trial;
  logic [sird_pkg::RADIX_W-1:0]  rem_next;
  logic                          ge;

  // Shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial    = {rem, q[VALUE_WIDTH-1]};
    ge       = (trial >= divisor);
    rem_next = ge ? (trial - divisor) : trial;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == STEP_W'(VALUE_WIDTH - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(VALUE_WIDTH - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      q   <= {q[VALUE_WIDTH-2:0], ge};
      rem <= rem_next[sird_pkg::DIGIT_W-1:0];
    end
  end

  assign quotient = q;
  assign res.done = done;
  assign res.rem  = rem;

endmodule
